[rtl/pcd_pkg.sv]
// Package: shared constants for the prefix code tree decoder.
`default_nettype none
package pcd_pkg;

    localparam int DEF_MAX_NODES    = 512;
    localparam int DEF_MAX_CODE_LEN = 32;

    localparam int CODE_W = 32;
    localparam int SYM_W  = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

endpackage
`default_nettype wire

[rtl/prefix_code_tree_decoder.sv]
// Top level: prefix code tree decoder with node memory, load and walk sequencer.
`default_nettype none
// Huffman decoder. Raise start with an item while busy is low. A load item
// (operation 0) inserts one code into the tree. A decode item (operation 1)
// walks the tree over bits_valid bits of data_byte, MSB first, with one node
// memory read and one evaluation per bit. Node memory reads are registered.
// Results appear for one cycle each with strobe high and cannot be held off;
// zero to eight symbol results (kind 0) are followed by one status result
// (kind 1, last 1). The walk position is kept across decode items, so a
// code may span bytes. After reset the node memory is cleared, one entry a
// cycle, during which busy stays high.
module prefix_code_tree_decoder
    import pcd_pkg::*;
#(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [31:0] code_bits,
    input  wire logic [5:0]  code_length,
    input  wire logic [7:0]  symbol,
    input  wire logic [7:0]  data_byte,
    input  wire logic [3:0]  bits_valid,
    output logic             strobe,
    output logic             kind,
    output logic [7:0]       decoded_symbol,
    output logic [1:0]       status,
    output logic             last
);

    localparam int AW = $clog2(MAX_NODES);
    // entry: {tagged, symbol, right, left}
    localparam int EW = 2 * AW + SYM_W + 1;

    typedef enum logic [5:0] {
        S_CLR   = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LSTEP = 6'b000100,
        S_DSTEP = 6'b001000,
        S_DLAND = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    // Node memory
    logic [EW-1:0] mem [MAX_NODES];
    logic [EW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [AW:0]     free_reg, free_next;
    logic [AW-1:0]   walk_reg, walk_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [5:0]      rem_reg, rem_next;
    logic [31:0]     shift_reg, shift_next;
    logic [7:0]      sym_reg, sym_next;
    logic [1:0]      st_reg, st_next;
    logic            fresh_reg, fresh_next;   // freshly allocated node reads as zero
    logic            strobe_reg, strobe_next;
    logic            kind_reg, kind_next;
    logic [7:0]      dsym_reg, dsym_next;
    logic [1:0]      status_reg, status_next;
    logic            last_reg, last_next;

    logic [EW-1:0]   cur_data;
    logic [AW-1:0]   cur_left, cur_right, child;
    logic [7:0]      cur_sym;
    logic            cur_tag, bit_now, len_bad, cnt_bad;

    assign cur_data  = fresh_reg ? '0 : rdata_reg;
    assign cur_left  = cur_data[AW-1:0];
    assign cur_right = cur_data[2*AW-1:AW];
    assign cur_sym   = cur_data[2*AW+7:2*AW];
    assign cur_tag   = cur_data[EW-1];
    assign bit_now   = shift_reg[31];
    assign child     = bit_now ? cur_right : cur_left;
    assign len_bad   = (code_length == 6'd0) || (code_length > 6'd32)
                       || (int'(code_length) > MAX_CODE_LEN);
    assign cnt_bad   = (bits_valid == 4'd0) || (bits_valid > 4'd8);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        free_next    = free_reg;
        walk_next    = walk_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        sym_next     = sym_reg;
        st_next      = st_reg;
        fresh_next   = fresh_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        dsym_next    = dsym_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        we           = 1'b0;
        waddr        = cur_reg;
        wdata        = cur_data;
        re           = 1'b0;
        raddr        = '0;

        unique case (state_reg)
            S_CLR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_LOAD)
                    begin
                        if (len_bad)
                        begin
                            st_next    = ST_BADLEN;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            shift_next = code_bits << (6'd32 - code_length);
                            rem_next   = code_length;
                            sym_next   = symbol;
                            cur_next   = '0;
                            re         = 1'b1;
                            raddr      = '0;
                            fresh_next = 1'b0;
                            state_next = S_LSTEP;
                        end
                    end
                    else
                    begin
                        if (cnt_bad)
                        begin
                            st_next    = ST_BADLEN;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            shift_next = {data_byte, 24'd0};
                            rem_next   = {2'b00, bits_valid};
                            st_next    = ST_OK;
                            re         = 1'b1;
                            raddr      = walk_reg;
                            fresh_next = 1'b0;
                            state_next = S_DSTEP;
                        end
                    end
                end
            end
            S_LSTEP:
            begin
                if (rem_reg == 6'd0)
                begin
                    we         = 1'b1;
                    waddr      = cur_reg;
                    wdata      = {1'b1, sym_reg, cur_right, cur_left};
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
                else if (child != '0)
                begin
                    re         = 1'b1;
                    raddr      = child;
                    fresh_next = 1'b0;
                    cur_next   = child;
                    rem_next   = rem_reg - 1'b1;
                    shift_next = shift_reg << 1;
                end
                else if (free_reg >= (AW + 1)'(MAX_NODES))
                begin
                    st_next    = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = cur_reg;
                    wdata      = bit_now ? {cur_tag, cur_sym, free_reg[AW-1:0], cur_left}
                                         : {cur_tag, cur_sym, cur_right, free_reg[AW-1:0]};
                    cur_next   = free_reg[AW-1:0];
                    free_next  = free_reg + 1'b1;
                    fresh_next = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    shift_next = shift_reg << 1;
                end
            end
            S_DSTEP:
            begin
                if (child == '0)
                begin
                    walk_next  = '0;
                    st_next    = ST_MISSING;
                    state_next = S_FIN;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = child;
                    cur_next   = child;
                    state_next = S_DLAND;
                end
            end
            S_DLAND:
            begin
                shift_next = shift_reg << 1;
                rem_next   = rem_reg - 1'b1;
                if (cur_left == '0 && cur_right == '0)
                begin
                    walk_next = '0;
                    if (!cur_tag)
                    begin
                        st_next    = ST_MISSING;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        kind_next   = KIND_SYMBOL;
                        dsym_next   = cur_sym;
                        status_next = ST_OK;
                        last_next   = 1'b0;
                        if (rem_reg == 6'd1)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_DSTEP;
                        end
                    end
                end
                else
                begin
                    // inner node: its data stays in the read register
                    walk_next  = cur_reg;
                    state_next = (rem_reg == 6'd1) ? S_FIN : S_DSTEP;
                end
            end
            S_FIN:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_STATUS;
                dsym_next   = '0;
                status_next = st_reg;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            free_reg    <= (AW + 1)'(1);
            walk_reg    <= '0;
            fresh_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            free_reg    <= free_next;
            walk_reg    <= walk_next;
            fresh_reg   <= fresh_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        rem_reg    <= rem_next;
        shift_reg  <= shift_next;
        sym_reg    <= sym_next;
        st_reg     <= st_next;
        kind_reg   <= kind_next;
        dsym_reg   <= dsym_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign strobe         = strobe_reg;
    assign kind           = kind_reg;
    assign decoded_symbol = dsym_reg;
    assign status         = status_reg;
    assign last           = last_reg;

    // Assertions
    a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_SYMBOL) |-> (status == ST_OK && !last))
        else $error("symbol item with status or last set");

    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (kind == KIND_STATUS))
        else $error("last item is not a status");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("item straight after the final one");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= (AW + 1)'(MAX_NODES))
        else $error("free node pointer beyond store");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (strobe && last))
        else $error("finish without status item");

endmodule
`default_nettype wire

[dv/prefix_code_tree_decoder_test.sv]
// Testbench for the prefix code tree decoder: directed and random load/decode items.
`timescale 1ns / 1ps
`default_nettype none
module prefix_code_tree_decoder_test;
    import pcd_pkg::*;

    localparam int NODES    = DEF_MAX_NODES;
    localparam int CODE_MAX = DEF_MAX_CODE_LEN;
    localparam int WATCHDOG = 20000;

    // one expected or observed result item
    typedef struct packed {
        logic       kind;
        logic [7:0] sym;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Tree predictor plus queue of pending results.
    class decode_scoreboard;
        int unsigned left_of[NODES];
        int unsigned right_of[NODES];
        logic [7:0]  sym_of[NODES];
        bit          has_sym[NODES];
        int unsigned free_node;
        int unsigned walk_at;
        result_t     pending[$];
        int          errors;
        int          checked;

        function void clear();
            foreach (left_of[i])
            begin
                left_of[i] = 0;
                right_of[i] = 0;
                sym_of[i] = '0;
                has_sym[i] = 0;
            end
            free_node = 1;
            walk_at = 0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void push(logic k, logic [7:0] s, logic [1:0] st, logic l);
            result_t r;
            r.kind = k;
            r.sym = s;
            r.status = st;
            r.last = l;
            pending.push_back(r);
        endfunction

        function logic [1:0] insert_code(logic [31:0] bits, int unsigned len,
                                         logic [7:0] s);
            int unsigned node;
            int unsigned nb;
            logic b;
            node = 0;
            if (len == 0 || len > 32 || len > CODE_MAX)
                return ST_BADLEN;
            for (int unsigned i = 0; i < len; i++)
            begin
                b = bits[len - 1 - i];
                nb = b ? right_of[node] : left_of[node];
                if (nb == 0)
                begin
                    if (free_node >= NODES)
                        return ST_FULL;
                    nb = free_node;
                    if (b)
                        right_of[node] = nb;
                    else
                        left_of[node] = nb;
                    free_node++;
                end
                node = nb % NODES;
            end
            sym_of[node] = s;
            has_sym[node] = 1;
            return ST_OK;
        endfunction

        // note an accepted input item
        function void note_item(logic op, logic [31:0] bits, logic [5:0] len,
                                logic [7:0] s, logic [7:0] db, logic [3:0] cnt);
            logic [1:0] st;
            int unsigned nx;
            if (op == OP_LOAD)
            begin
                push(KIND_STATUS, 8'h00, insert_code(bits, len, s), 1'b1);
                return;
            end
            if (cnt == 0 || cnt > 8)
            begin
                push(KIND_STATUS, 8'h00, ST_BADLEN, 1'b1);
                return;
            end
            st = ST_OK;
            for (int i = 0; i < cnt; i++)
            begin
                nx = db[7 - i] ? right_of[walk_at] : left_of[walk_at];
                if (nx == 0)
                begin
                    walk_at = 0;
                    st = ST_MISSING;
                    break;
                end
                nx = nx % NODES;
                if (left_of[nx] == 0 && right_of[nx] == 0)
                begin
                    walk_at = 0;
                    if (!has_sym[nx])
                    begin
                        st = ST_MISSING;
                        break;
                    end
                    push(KIND_SYMBOL, sym_of[nx], ST_OK, 1'b0);
                end
                else
                    walk_at = nx;
            end
            push(KIND_STATUS, 8'h00, st, 1'b1);
        endfunction

        // compare one result against the oldest expectation
        function void check_result(result_t got);
            result_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d sym=%02h status=%0d last=%0d",
                         $time, got.kind, got.sym, got.status, got.last);
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind)
            begin
                errors++;
                $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
            end
            if (got.sym !== exp_r.sym)
            begin
                errors++;
                $display("%0t: symbol expected %02h actual %02h", $time, exp_r.sym, got.sym);
            end
            if (got.status !== exp_r.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_r.status, got.status);
            end
            if (got.last !== exp_r.last)
            begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic [7:0]  symbol;
    logic [7:0]  data_byte;
    logic [3:0]  bits_valid;
    logic        strobe;
    logic        kind;
    logic [7:0]  decoded_symbol;
    logic [1:0]  status;
    logic        last;

    decode_scoreboard board;
    int          quiet_cycles;
    int          items_sent;
    int          gaps_on;
    int          loads_sent;
    int          decodes_sent;

    // live code table used to build well-formed streams
    logic [31:0] book_bits[$];
    int          book_len[$];

    prefix_code_tree_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .code_bits      (code_bits),
        .code_length    (code_length),
        .symbol         (symbol),
        .data_byte      (data_byte),
        .bits_valid     (bits_valid),
        .strobe         (strobe),
        .kind           (kind),
        .decoded_symbol (decoded_symbol),
        .status         (status),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Results cannot be stalled: sample every strobe at the edge ending it.
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && strobe)
        begin
            r.kind = kind;
            r.sym = decoded_symbol;
            r.status = status;
            r.last = last;
            board.check_result(r);
        end
    end

    // Watchdog: any accepted input or result resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("prefix_code_tree_decoder_test: errors");
            $finish;
        end
    end

    // Present one item and hold it until accepted; start drops afterwards
    // only when a sender gap follows, so it never toggles within a step.
    task automatic send_item(logic op, logic [31:0] bits, logic [5:0] len,
                             logic [7:0] s, logic [7:0] db, logic [3:0] cnt);
        int gap;
        operation   <= op;
        code_bits   <= bits;
        code_length <= len;
        symbol      <= s;
        data_byte   <= db;
        bits_valid  <= cnt;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(op, bits, len, s, db, cnt);
        items_sent++;
        if (op == OP_LOAD)
            loads_sent++;
        else
            decodes_sent++;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_code(logic [31:0] bits, int len, logic [7:0] s);
        send_item(OP_LOAD, bits, len[5:0], s, 8'($urandom), 4'($urandom));
    endtask

    task automatic decode_byte(logic [7:0] db, int cnt);
        send_item(OP_DECODE, $urandom, 6'($urandom), 8'($urandom), db, cnt[3:0]);
    endtask

    // Pause the sender until every expected result has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Emit a bit string as stream bytes, random tails left for the next call.
    logic [7:0] acc_byte;
    int         acc_cnt;

    task automatic push_bit(logic b);
        acc_byte[7 - acc_cnt] = b;
        acc_cnt++;
        if (acc_cnt == 8)
        begin
            decode_byte(acc_byte, 8);
            acc_cnt = 0;
            acc_byte = 8'($urandom);
        end
    endtask

    task automatic flush_bits();
        if (acc_cnt > 0)
            decode_byte(acc_byte, acc_cnt);
        acc_cnt = 0;
        acc_byte = 8'($urandom);
    endtask

    // Build a complete prefix code of n leaves by random splits.
    task automatic build_code_book(int n);
        int pick;
        logic [31:0] b;
        int l;
        book_bits.delete();
        book_len.delete();
        book_bits.push_back(32'd0);
        book_len.push_back(1);
        book_bits.push_back(32'd1);
        book_len.push_back(1);
        while (book_bits.size() < n)
        begin
            pick = $urandom_range(0, book_bits.size() - 1);
            if (book_len[pick] >= 12)
                continue;
            b = book_bits[pick];
            l = book_len[pick];
            book_bits.delete(pick);
            book_len.delete(pick);
            book_bits.push_back({b[30:0], 1'b0});
            book_len.push_back(l + 1);
            book_bits.push_back({b[30:0], 1'b1});
            book_len.push_back(l + 1);
        end
    endtask

    int k;
    int n_codes;
    int target;

    initial
    begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_LOAD;
        code_bits = '0;
        code_length = 6'd1;
        symbol = '0;
        data_byte = '0;
        bits_valid = 4'd8;
        quiet_cycles = 0;
        items_sent = 0;
        loads_sent = 0;
        decodes_sent = 0;
        gaps_on = 0;
        acc_cnt = 0;
        acc_byte = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tree, bad lengths, bad bit counts
        decode_byte(8'h80, 1);
        load_code(32'h0, 0, 8'h11);
        load_code(32'hFFFF_FFFF, 33, 8'h12);
        load_code(32'hFFFF_FFFF, 63, 8'h13);
        decode_byte(8'hFF, 0);
        decode_byte(8'hFF, 9);
        decode_byte(8'hFF, 15);
        // longest codes, all ones and all zeros, extreme symbols
        load_code(32'hFFFF_FFFF, 32, 8'hFF);
        load_code(32'h0000_0000, 32, 8'h00);
        // short prefix code plus a prefix of an existing leaf, and a reload
        load_code(32'h2, 2, 8'hA5);
        load_code(32'h2, 2, 8'h5A);
        load_code(32'h6, 3, 8'h3C);
        load_code(32'h7, 3, 8'hC3);
        decode_byte(8'b10110111, 8);
        decode_byte(8'b10100000, 3);
        // missing branch mid-byte (01... has no path)
        decode_byte(8'b01000000, 8);
        // walk into all-ones chain, then span bytes to its leaf
        decode_byte(8'hFF, 8);
        decode_byte(8'hFF, 8);
        decode_byte(8'hFF, 8);
        decode_byte(8'hFF, 8);
        // zero chain spanning bytes
        decode_byte(8'h00, 8);
        decode_byte(8'h00, 8);
        decode_byte(8'h00, 8);
        decode_byte(8'h00, 8);
        drain();

        // random: codebooks with well-formed streams, some noise
        gaps_on = 1;
        target = 330;
        while (items_sent < target)
        begin
            n_codes = $urandom_range(2, 24);
            build_code_book(n_codes);
            // junk above the code length must be ignored
            for (int i = 0; i < book_bits.size(); i++)
                load_code(book_bits[i] | ($urandom << book_len[i]),
                          book_len[i], 8'($urandom));
            // noise loads: wild codes and lengths
            repeat ($urandom_range(0, 2))
                load_code($urandom, $urandom_range(0, 63), 8'($urandom));
            acc_cnt = 0;
            acc_byte = 8'($urandom);
            repeat ($urandom_range(4, 20))
            begin
                k = $urandom_range(0, book_bits.size() - 1);
                for (int j = book_len[k] - 1; j >= 0; j--)
                    push_bit(book_bits[k][j]);
                if ($urandom_range(0, 5) == 0)
                    flush_bits();
            end
            flush_bits();
            repeat ($urandom_range(0, 3))
                decode_byte(8'($urandom), $urandom_range(0, 15));
            if (items_sent > 280)
                gaps_on = 0;
            // sender pause between some books, chosen at random
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        // exhaust the node store with long random codes
        gaps_on = 0;
        while (board.free_node < NODES)
            load_code($urandom, 32, 8'($urandom));
        load_code($urandom, 32, 8'($urandom));
        load_code($urandom, 32, 8'($urandom));
        repeat (10)
            decode_byte(8'($urandom), $urandom_range(1, 8));

        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d items (%0d loads, %0d decodes); checked %0d results.",
                 items_sent, loads_sent, decodes_sent, board.checked);
        $display("Covered bad lengths, prefix and reloaded codes, spanning walks, full store.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("prefix_code_tree_decoder_test: clean");
        else
            $display("prefix_code_tree_decoder_test: errors");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
rtl/pcd_pkg.sv
rtl/prefix_code_tree_decoder.sv
dv/prefix_code_tree_decoder_test.sv
